// ----- rtl/bae_pkg.sv -----
// Shared types, constants and lookup tables for the breakpoint automation evaluator.
package bae_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int POINTS_DEF   = 32;
  localparam int FRAC_DEF     = 16;
  localparam int QDEPTH       = 2;

  typedef enum logic [2:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_CLEAR  = 3'd2,
    FN_EVAL   = 3'd3,
    FN_CLRALL = 3'd4
  } func_e_t;

  typedef enum logic [1:0] {
    CV_LINEAR = 2'd0,
    CV_SMOOTH = 2'd1,
    CV_EXP    = 2'd2,
    CV_HOLD   = 2'd3
  } curve_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         channel;
    logic [31:0]        event_time;
    logic signed [31:0] point_value;
    logic [1:0]         curve_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    func_e_t            op;
    logic               ch_ok;
    logic [2:0]         channel;
    logic [31:0]        event_time;
    logic signed [31:0] point_value;
    logic [1:0]         curve_kind;
  } cmd_t;

  function automatic logic [16:0] smooth_tab(input logic [4:0] i);
    case (i)
      5'd0: smooth_tab = 17'd0;      5'd1: smooth_tab = 17'd630;
      5'd2: smooth_tab = 17'd2494;   5'd3: smooth_tab = 17'd5522;
      5'd4: smooth_tab = 17'd9598;   5'd5: smooth_tab = 17'd14563;
      5'd6: smooth_tab = 17'd20228;  5'd7: smooth_tab = 17'd26375;
      5'd8: smooth_tab = 17'd32768;  5'd9: smooth_tab = 17'd39161;
      5'd10: smooth_tab = 17'd45308; 5'd11: smooth_tab = 17'd50973;
      5'd12: smooth_tab = 17'd55938; 5'd13: smooth_tab = 17'd60014;
      5'd14: smooth_tab = 17'd63042; 5'd15: smooth_tab = 17'd64906;
      default: smooth_tab = 17'd65536;
    endcase
  endfunction

  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    case (i)
      5'd0: log2_tab = 17'd0;      5'd1: log2_tab = 17'd5732;
      5'd2: log2_tab = 17'd11136;  5'd3: log2_tab = 17'd16248;
      5'd4: log2_tab = 17'd21098;  5'd5: log2_tab = 17'd25711;
      5'd6: log2_tab = 17'd30110;  5'd7: log2_tab = 17'd34312;
      5'd8: log2_tab = 17'd38336;  5'd9: log2_tab = 17'd42196;
      5'd10: log2_tab = 17'd45904; 5'd11: log2_tab = 17'd49473;
      5'd12: log2_tab = 17'd52911; 5'd13: log2_tab = 17'd56229;
      5'd14: log2_tab = 17'd59434; 5'd15: log2_tab = 17'd62534;
      default: log2_tab = 17'd65536;
    endcase
  endfunction

  function automatic logic [17:0] exp2_tab(input logic [4:0] i);
    case (i)
      5'd0: exp2_tab = 18'd65536;   5'd1: exp2_tab = 18'd68438;
      5'd2: exp2_tab = 18'd71468;   5'd3: exp2_tab = 18'd74632;
      5'd4: exp2_tab = 18'd77936;   5'd5: exp2_tab = 18'd81386;
      5'd6: exp2_tab = 18'd84990;   5'd7: exp2_tab = 18'd88752;
      5'd8: exp2_tab = 18'd92682;   5'd9: exp2_tab = 18'd96785;
      5'd10: exp2_tab = 18'd101070; 5'd11: exp2_tab = 18'd105544;
      5'd12: exp2_tab = 18'd110218; 5'd13: exp2_tab = 18'd115098;
      5'd14: exp2_tab = 18'd120194; 5'd15: exp2_tab = 18'd125515;
      default: exp2_tab = 18'd131072;
    endcase
  endfunction

  typedef enum logic [4:0] {
    B_IDLE, B_RD0, B_WT0, B_CHK0, B_RDL, B_WTL, B_CHKL,
    B_SCAN, B_SWT, B_SCHK, B_DIV, B_CURVE, B_LOG0, B_LOG1,
    B_LMIX, B_EXP, B_EXPF, B_MUL, B_FIN, B_OUT,
    B_ASH, B_ASHW, B_AWR, B_RMR, B_RMW, B_RMCK
  } bstate_t;

endpackage

// ----- rtl/bae_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module bae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/bae_front.sv -----
// Front end: accepts requests, classifies them and queues commands for the back end.
module bae_front #(
  parameter int CHANNELS = bae_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bae_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output bae_pkg::cmd_t    cmd
);
  localparam int QW = $clog2(bae_pkg::QDEPTH);

  bae_pkg::cmd_t q_r [bae_pkg::QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  bae_pkg::cmd_t cl;
  logic push, pop;

  always_comb begin
    cl.op          = bae_pkg::func_e_t'(in_data.func);
    cl.ch_ok       = {29'd0, in_data.channel} < CHANNELS;
    cl.channel     = in_data.channel;
    cl.event_time  = in_data.event_time;
    cl.point_value = in_data.point_value;
    cl.curve_kind  = in_data.curve_kind;
  end

  assign in_ready  = cnt_r < (QW+1)'(bae_pkg::QDEPTH);
  assign push      = in_valid && in_ready;
  assign cmd_valid = cnt_r != '0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cl;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule

// ----- rtl/bae_back.sv -----
// Back end: point table upkeep and segment evaluation sequencer.
module bae_back #(
  parameter int CHANNELS  = bae_pkg::CHANNELS_DEF,
  parameter int POINTS    = bae_pkg::POINTS_DEF,
  parameter int FRAC_BITS = bae_pkg::FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  bae_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output bae_pkg::out_item_t out_data
);
  localparam int PW  = $clog2(POINTS);
  localparam int CW  = $clog2(POINTS + 1);
  localparam int AW  = 3 + PW;
  localparam int DEP = 8 << PW;
  localparam int EPS0 = ((1 << FRAC_BITS) + 5000) / 10000;
  localparam logic [31:0] EPS = (EPS0 == 0) ? 32'd1 : 32'(EPS0);
  localparam logic signed [63:0] MAXV = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] MINV = -64'sh8000_0000;

  bae_pkg::bstate_t st_r, st_nxt;
  bae_pkg::cmd_t    c_r, c_nxt;
  logic [CW-1:0] cnt_r [CHANNELS];
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [31:0] t0_r, t0_nxt;
  logic signed [31:0] v0_r, v0_nxt, v1_r, v1_nxt;
  logic [1:0]  k0_r, k0_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [31:0] dur_r, dur_nxt;
  logic [16:0] u_r, u_nxt;
  logic [5:0]  dc_r, dc_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [31:0] l0_r, l0_nxt, l1_r, l1_nxt, lm_r, lm_nxt;
  logic signed [63:0] ex_r, ex_nxt, lin_r, lin_nxt;
  logic signed [63:0] res_r, res_nxt;
  logic [1:0]  sts_r, sts_nxt;
  logic        ov_r, ov_nxt;
  bae_pkg::out_item_t od_r, od_nxt;

  logic we;
  logic [AW-1:0] wa, ra;
  logic [65:0] wd, rd;
  logic [31:0] rd_t;
  logic signed [31:0] rd_v;
  logic [1:0] rd_k;

  bae_ram #(.WIDTH(66), .DEPTH(DEP)) u_pts (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));

  assign rd_t = rd[65:34];
  assign rd_v = rd[33:2];
  assign rd_k = rd[1:0];
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cmd_ready = (st_r == bae_pkg::B_IDLE) && !ov_r;

  function automatic logic [AW-1:0] adr(input logic [2:0] ch, input logic [CW-1:0] k);
    adr = {ch, k[PW-1:0]};
  endfunction

  function automatic logic [16:0] tinterp17(input logic [16:0] a, input logic [16:0] b,
                                           input logic [11:0] r);
    logic [29:0] p;
    p = 30'(b - a) * 30'(r) + 30'd2048;
    tinterp17 = a + 17'(p >> 12);
  endfunction

  function automatic logic [31:0] log2q(input logic [31:0] raw);
    logic [4:0] p;
    logic [15:0] f;
    logic [31:0] sh;
    p = 5'd0;
    for (int b = 1; b < 32; b++) begin
      if (raw[b]) p = 5'(b);
    end
    sh = raw << (5'd31 - p);
    f = sh[30:15];
    if (f[15:12] == 4'd15)
      log2q = {11'd0, p, 16'd0} + 32'(tinterp17(bae_pkg::log2_tab(5'd15),
                                                bae_pkg::log2_tab(5'd16), f[11:0]));
    else
      log2q = {11'd0, p, 16'd0} + 32'(tinterp17(bae_pkg::log2_tab({1'b0, f[15:12]}),
                                                bae_pkg::log2_tab({1'b0, f[15:12]} + 5'd1),
                                                f[11:0]));
  endfunction

  // linear mix: v0 + floor(((v1-v0)*u + 32768) / 65536)
  function automatic logic signed [63:0] mixl(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input logic [16:0] u);
    logic signed [63:0] p;
    p = (64'(b) - 64'(a)) * $signed({47'd0, u}) + 64'sd32768;
    mixl = 64'(a) + (p >>> 16);
  endfunction

  logic signed [63:0] ld;
  logic [17:0] m_tab;
  logic [18:0] m;
  logic [4:0] ip;
  logic [63:0] rr;
  logic [16:0] s_u;
  logic [29:0] mp;

  always_comb begin
    st_nxt = st_r; c_nxt = c_r; n_nxt = n_r; i_nxt = i_r; j_nxt = j_r;
    t0_nxt = t0_r; v0_nxt = v0_r; v1_nxt = v1_r; k0_nxt = k0_r;
    rem_nxt = rem_r; dur_nxt = dur_r; u_nxt = u_r; dc_nxt = dc_r; quo_nxt = quo_r;
    l0_nxt = l0_r; l1_nxt = l1_r; lm_nxt = lm_r; ex_nxt = ex_r; lin_nxt = lin_r;
    res_nxt = res_r; sts_nxt = sts_r; ov_nxt = ov_r; od_nxt = od_r;
    we = 1'b0; wa = '0; wd = '0; ra = adr(c_r.channel, i_r);
    ld = '0; m_tab = '0; m = '0; ip = '0; rr = '0; s_u = '0; mp = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      bae_pkg::B_IDLE: begin
        if (cmd_valid && !ov_r) begin
          c_nxt = cmd;
          n_nxt = cmd.ch_ok ? cnt_r[cmd.channel] : '0;
          res_nxt = '0;
          sts_nxt = bae_pkg::ST_OK;
          st_nxt = bae_pkg::B_OUT;
          case (cmd.op)
            bae_pkg::FN_ADD: begin
              if (cmd.ch_ok) begin
                if (cnt_r[cmd.channel] >= CW'(POINTS)) sts_nxt = bae_pkg::ST_FULL;
                else begin
                  i_nxt = cnt_r[cmd.channel];
                  st_nxt = bae_pkg::B_ASH;
                end
              end
            end
            bae_pkg::FN_REMOVE: begin
              if (cmd.ch_ok) begin
                i_nxt = '0; j_nxt = '0; st_nxt = bae_pkg::B_RMR;
              end
            end
            bae_pkg::FN_EVAL: begin
              if (!cmd.ch_ok || cnt_r[cmd.channel] == '0) sts_nxt = bae_pkg::ST_EMPTY;
              else begin
                i_nxt = '0; st_nxt = bae_pkg::B_RD0;
              end
            end
            default: ;
          endcase
        end
      end
      // insert: shift larger entries up by one
      bae_pkg::B_ASH: begin
        if (i_r == '0) st_nxt = bae_pkg::B_AWR;
        else begin
          ra = adr(c_r.channel, i_r - 1'b1);
          st_nxt = bae_pkg::B_ASHW;
        end
      end
      bae_pkg::B_ASHW: begin
        if (rd_t > c_r.event_time) begin
          we = 1'b1; wa = adr(c_r.channel, i_r); wd = rd;
          i_nxt = i_r - 1'b1;
          st_nxt = bae_pkg::B_ASH;
        end else st_nxt = bae_pkg::B_AWR;
      end
      bae_pkg::B_AWR: begin
        we = 1'b1; wa = adr(c_r.channel, i_r);
        wd = {c_r.event_time, c_r.point_value, c_r.curve_kind};
        st_nxt = bae_pkg::B_OUT;
      end
      // remove: compact
      bae_pkg::B_RMR: begin
        if (i_r >= n_r) st_nxt = bae_pkg::B_OUT;
        else st_nxt = bae_pkg::B_RMW;
      end
      bae_pkg::B_RMW: st_nxt = bae_pkg::B_RMCK;
      bae_pkg::B_RMCK: begin
        if (rd_t != c_r.event_time) begin
          we = 1'b1; wa = adr(c_r.channel, j_r); wd = rd;
          j_nxt = j_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
        st_nxt = bae_pkg::B_RMR;
      end
      // evaluate
      bae_pkg::B_RD0: st_nxt = bae_pkg::B_WT0;
      bae_pkg::B_WT0: st_nxt = bae_pkg::B_CHK0;
      bae_pkg::B_CHK0: begin
        t0_nxt = rd_t; v0_nxt = rd_v;
        if (c_r.event_time <= rd_t) begin
          res_nxt = 64'(rd_v); st_nxt = bae_pkg::B_OUT;
        end else begin
          i_nxt = n_r - 1'b1; st_nxt = bae_pkg::B_RDL;
        end
      end
      bae_pkg::B_RDL: st_nxt = bae_pkg::B_WTL;
      bae_pkg::B_WTL: st_nxt = bae_pkg::B_CHKL;
      bae_pkg::B_CHKL: begin
        if (c_r.event_time >= rd_t) begin
          res_nxt = 64'(rd_v); st_nxt = bae_pkg::B_OUT;
        end else begin
          i_nxt = '0; st_nxt = bae_pkg::B_SCAN;
        end
      end
      bae_pkg::B_SCAN: begin
        ra = adr(c_r.channel, i_r);
        st_nxt = bae_pkg::B_SWT;
      end
      bae_pkg::B_SWT: begin
        ra = adr(c_r.channel, i_r + 1'b1);
        t0_nxt = rd_t; v0_nxt = rd_v; k0_nxt = rd_k;
        st_nxt = bae_pkg::B_SCHK;
      end
      bae_pkg::B_SCHK: begin
        v1_nxt = rd_v;
        if (c_r.event_time >= t0_r && c_r.event_time <= rd_t) begin
          dur_nxt = rd_t - t0_r;
          rem_nxt = '0;
          quo_nxt = {c_r.event_time - t0_r, 16'd0};
          dc_nxt = 6'd48;
          st_nxt = bae_pkg::B_DIV;
        end else begin
          i_nxt = i_r + 1'b1;
          st_nxt = bae_pkg::B_SCAN;
        end
      end
      // restoring divide, one bit per cycle
      bae_pkg::B_DIV: begin
        if (dur_r == '0) begin
          u_nxt = '0; st_nxt = bae_pkg::B_CURVE;
        end else if (dc_r == '0) begin
          u_nxt = (quo_r > 48'd65536) ? 17'd65536 : quo_r[16:0];
          st_nxt = bae_pkg::B_CURVE;
        end else begin
          rem_nxt = {rem_r[46:0], quo_r[47]};
          quo_nxt = {quo_r[46:0], 1'b0};
          if ({rem_r[46:0], quo_r[47]} >= {16'd0, dur_r}) begin
            rem_nxt = {rem_r[46:0], quo_r[47]} - {16'd0, dur_r};
            quo_nxt[0] = 1'b1;
          end
          dc_nxt = dc_r - 1'b1;
        end
      end
      bae_pkg::B_CURVE: begin
        case (bae_pkg::curve_t'(k0_r))
          bae_pkg::CV_LINEAR: begin
            lin_nxt = mixl(v0_r, v1_r, u_r); st_nxt = bae_pkg::B_FIN;
          end
          bae_pkg::CV_SMOOTH: begin
            if (u_r[16]) s_u = bae_pkg::smooth_tab(5'd16);
            else s_u = tinterp17(bae_pkg::smooth_tab({1'b0, u_r[15:12]}),
                                 bae_pkg::smooth_tab({1'b0, u_r[15:12]} + 5'd1),
                                 u_r[11:0]);
            u_nxt = s_u;
            k0_nxt = bae_pkg::CV_LINEAR;
            st_nxt = bae_pkg::B_CURVE;
          end
          bae_pkg::CV_EXP: begin
            lin_nxt = mixl(v0_r, v1_r, u_r);
            if (v0_r <= 0 && v1_r <= 0) st_nxt = bae_pkg::B_FIN;
            else st_nxt = bae_pkg::B_LOG0;
          end
          default: begin
            lin_nxt = 64'(v0_r); st_nxt = bae_pkg::B_FIN;
          end
        endcase
      end
      bae_pkg::B_LOG0: begin
        l0_nxt = log2q(v0_r > 0 ? v0_r : EPS);
        st_nxt = bae_pkg::B_LOG1;
      end
      bae_pkg::B_LOG1: begin
        l1_nxt = log2q(v1_r > 0 ? v1_r : EPS);
        st_nxt = bae_pkg::B_LMIX;
      end
      bae_pkg::B_LMIX: begin
        ld = ($signed({32'd0, l1_r}) - $signed({32'd0, l0_r})) * $signed({47'd0, u_r});
        lm_nxt = 32'($signed({32'd0, l0_r}) + (ld >>> 16));
        st_nxt = bae_pkg::B_EXP;
      end
      bae_pkg::B_EXP: begin
        if (lm_r[15:12] == 4'd15)
          mp = 30'(bae_pkg::exp2_tab(5'd16) - bae_pkg::exp2_tab(5'd15)) * 30'(lm_r[11:0]);
        else
          mp = 30'(bae_pkg::exp2_tab({1'b0, lm_r[15:12]} + 5'd1)
                   - bae_pkg::exp2_tab({1'b0, lm_r[15:12]})) * 30'(lm_r[11:0]);
        m_tab = bae_pkg::exp2_tab({1'b0, lm_r[15:12]});
        ex_nxt = 64'(m_tab) + 64'((mp + 30'd2048) >> 12);
        st_nxt = bae_pkg::B_EXPF;
      end
      bae_pkg::B_EXPF: begin
        m = ex_r[18:0];
        ip = lm_r[20:16];
        if (lm_r[31:16] >= 16'd31) ex_nxt = MAXV;
        else begin
          if (ip >= 5'd16) rr = {45'd0, m} << (ip - 5'd16);
          else rr = ({45'd0, m} + ((64'd1 << (5'd16 - ip)) >> 1)) >> (5'd16 - ip);
          ex_nxt = (rr > 64'h7FFF_FFFF) ? MAXV : $signed(rr);
        end
        st_nxt = bae_pkg::B_MUL;
      end
      bae_pkg::B_MUL: begin
        if (v0_r <= 0 || v1_r <= 0) lin_nxt = (lin_r + ex_r) >>> 1;
        else lin_nxt = ex_r;
        st_nxt = bae_pkg::B_FIN;
      end
      bae_pkg::B_FIN: begin
        res_nxt = lin_r; st_nxt = bae_pkg::B_OUT;
      end
      bae_pkg::B_OUT: begin
        if (!ov_r) begin
          od_nxt.result_value = (res_r > MAXV) ? 32'sh7FFF_FFFF :
                                (res_r < MINV) ? 32'sh8000_0000 : res_r[31:0];
          od_nxt.status = sts_r;
          ov_nxt = 1'b1;
          st_nxt = bae_pkg::B_IDLE;
        end
      end
      default: st_nxt = bae_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt; n_r <= n_nxt; i_r <= i_nxt; j_r <= j_nxt;
    t0_r <= t0_nxt; v0_r <= v0_nxt; v1_r <= v1_nxt; k0_r <= k0_nxt;
    rem_r <= rem_nxt; dur_r <= dur_nxt; u_r <= u_nxt; dc_r <= dc_nxt; quo_r <= quo_nxt;
    l0_r <= l0_nxt; l1_r <= l1_nxt; lm_r <= lm_nxt; ex_r <= ex_nxt; lin_r <= lin_nxt;
    res_r <= res_nxt; sts_r <= sts_nxt; od_r <= od_nxt;
    if (!rst_n) begin
      st_r <= bae_pkg::B_IDLE;
      ov_r <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) cnt_r[k] <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (st_r == bae_pkg::B_AWR) cnt_r[c_r.channel] <= n_r + 1'b1;
      if (st_r == bae_pkg::B_RMR && i_r >= n_r) cnt_r[c_r.channel] <= j_r;
      if (st_r == bae_pkg::B_IDLE && cmd_valid && !ov_r) begin
        if (cmd.op == bae_pkg::FN_CLEAR && cmd.ch_ok) cnt_r[cmd.channel] <= '0;
        if (cmd.op == bae_pkg::FN_CLRALL)
          for (int k = 0; k < CHANNELS; k++) cnt_r[k] <= '0;
      end
    end
  end
endmodule

// ----- rtl/breakpoint_automation_evaluator_top.sv -----
// Top level of the breakpoint automation evaluator.
// Usage:
//   in_valid/in_ready carry one request (add, remove, clear channel,
//   evaluate, clear all) per transfer; out_valid/out_ready return exactly
//   one result per request, in order.
//   A front stage classifies requests into a two-entry queue; the back
//   sequencer serves one request at a time against a point memory of
//   CHANNELS*POINTS_PER_CHANNEL entries (one read port, registered).
//   Clears touch only the point counts; add, remove and evaluate step
//   through the n points in the channel, evaluate being dominated
//   by the segment scan over the memory port and the 48-step divider.
//   The back end serves one request at a time; the queue absorbs two more.
//   Reset clears the point counts, so every channel starts empty; no
//   memory sweep is needed.
//   A stalled receiver holds the result register; the back end then waits
//   and the front queue fills, after which in_ready drops.
module breakpoint_automation_evaluator_top #(
  parameter int CHANNELS           = bae_pkg::CHANNELS_DEF,
  parameter int POINTS_PER_CHANNEL = bae_pkg::POINTS_DEF,
  parameter int FRAC_BITS          = bae_pkg::FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bae_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bae_pkg::out_item_t out_data
);
  logic          cmd_valid, cmd_ready;
  bae_pkg::cmd_t cmd;

  bae_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));

  bae_back #(.CHANNELS(CHANNELS), .POINTS(POINTS_PER_CHANNEL),
             .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data));
endmodule
